### rtl/tllc_pkg.sv
// Shared types and constants of the two-level LRU cache tag model.
// No dependencies; used by the top level and the port-facing structs.
package tllc_pkg;

	localparam int ADDR_BITS = 13;

	localparam int L1_MAX_ROWS_DEF = 64;
	localparam int L1_MAX_WAYS_DEF = 4;
	localparam int L2_MAX_ROWS_DEF = 256;
	localparam int L2_MAX_WAYS_DEF = 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_L1_BLOCK_SHIFT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_L1_ROW_SHIFT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_L1_WAYS        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_L2_ENABLE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_L2_BLOCK_SHIFT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_L2_ROW_SHIFT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_L2_WAYS        = 3'd6;

	// result status codes
	localparam logic [1:0] ST_HIT  = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_SW   = 2'd2;

	localparam logic CMD_STORE = 1'b1;

	typedef struct packed {
		logic                 cmd;
		logic [ADDR_BITS-1:0] addr;
		logic [15:0]          pc_value;
	} req_t;

	typedef struct packed {
		logic                 level;
		logic [1:0]           status;
		logic [7:0]           row_index;
		logic [ADDR_BITS-1:0] addr_echo;
		logic [15:0]          pc_echo;
		logic                 last;
	} rsp_t;

endpackage

### rtl/two_level_lru_cache_tag_model.sv
// Top level of the two-level LRU cache tag model: sequencer, tag/age/valid
// memories for both levels, shared way scanner. Depends on tllc_pkg.
//
// Usage:
//  - Request channel (in_valid/in_ready/in_data): one access (load or store,
//    word address, pc). Taken only while the block is idle.
//  - Response channel (out_valid/out_ready/out_data): one result per level
//    that reports, L1 first; last marks the final result of an access.
//  - cfg_we/cfg_index/cfg_data write one of the seven setup registers a cycle.
//  Steps: an accept step, then per level an address/read step, a scan of
//  the ways, one way per cycle through the single tag comparator (stops
//  early at a hit or an empty way), and an update/write-back step. An
//  access covers L1 alone, or L1 and then L2.
//  The scan over ways through one comparator sets the pace of an access.
//  Reset: registers take their defaults, then a clearing pass over
//  max(L1_MAX_ROWS, L2_MAX_ROWS) rows zeroes the valid rows of both levels;
//  no request is taken meanwhile.
//  Stall: results sit in an output register; if the receiver stalls, the
//  update step of the next result waits until the register drains.
module two_level_lru_cache_tag_model #(
	parameter int L1_MAX_ROWS = tllc_pkg::L1_MAX_ROWS_DEF,
	parameter int L1_MAX_WAYS = tllc_pkg::L1_MAX_WAYS_DEF,
	parameter int L2_MAX_ROWS = tllc_pkg::L2_MAX_ROWS_DEF,
	parameter int L2_MAX_WAYS = tllc_pkg::L2_MAX_WAYS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  tllc_pkg::req_t                       in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output tllc_pkg::rsp_t                       out_data,
	input  logic                                 cfg_we,
	input  logic [tllc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tllc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import tllc_pkg::*;

	localparam int TW   = ADDR_BITS;
	localparam int MAXR = (L1_MAX_ROWS > L2_MAX_ROWS) ? L1_MAX_ROWS : L2_MAX_ROWS;
	localparam int MW   = (L1_MAX_WAYS > L2_MAX_WAYS) ? L1_MAX_WAYS : L2_MAX_WAYS;
	localparam int R1B  = (L1_MAX_ROWS > 1) ? $clog2(L1_MAX_ROWS) : 1;
	localparam int R2B  = (L2_MAX_ROWS > 1) ? $clog2(L2_MAX_ROWS) : 1;
	localparam int RBM  = (MAXR > 1) ? $clog2(MAXR) : 1;
	localparam int A1   = (L1_MAX_WAYS > 1) ? $clog2(L1_MAX_WAYS) : 1;
	localparam int A2   = (L2_MAX_WAYS > 1) ? $clog2(L2_MAX_WAYS) : 1;
	localparam int AW   = (A1 > A2) ? A1 : A2;
	localparam int IW   = (MW > 1) ? $clog2(MW) : 1;
	localparam int NWW  = $clog2(MW + 1);
	localparam int CW   = ((AW > NWW) ? AW : NWW) + 1;
	// largest usable row shift per level
	localparam int FL1  = $clog2(L1_MAX_ROWS + 1) - 1;
	localparam int FL2  = $clog2(L2_MAX_ROWS + 1) - 1;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_ADDR = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_UPD  = 3'd4;

	// setup registers
	logic [1:0] l1_bs_q, l2_bs_q;
	logic [2:0] l1_rs_q, l1_ways_q;
	logic [3:0] l2_rs_q, l2_ways_q;
	logic       l2_en_q;

	logic [2:0]    state_q;
	logic [RBM-1:0] clr_cnt_q;
	req_t          req_q;
	logic          level_q;
	logic [RBM-1:0] row_q;
	logic [TW-1:0] tag_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] w_q;
	logic [AW-1:0] best_q;
	logic [CW-1:0] old_q;
	logic          hit_q;
	logic          out_valid_q;
	rsp_t          out_q;

	// memories, one row per word
	logic [L1_MAX_WAYS-1:0]              l1_vmem [L1_MAX_ROWS];
	logic [L1_MAX_WAYS-1:0][TW-1:0]      l1_tmem [L1_MAX_ROWS];
	logic [L1_MAX_WAYS-1:0][A1-1:0]      l1_amem [L1_MAX_ROWS];
	logic [L2_MAX_WAYS-1:0]              l2_vmem [L2_MAX_ROWS];
	logic [L2_MAX_WAYS-1:0][TW-1:0]      l2_tmem [L2_MAX_ROWS];
	logic [L2_MAX_WAYS-1:0][A2-1:0]      l2_amem [L2_MAX_ROWS];

	logic [L1_MAX_WAYS-1:0]              l1_rd_v;
	logic [L1_MAX_WAYS-1:0][TW-1:0]      l1_rd_t;
	logic [L1_MAX_WAYS-1:0][A1-1:0]      l1_rd_a;
	logic [L2_MAX_WAYS-1:0]              l2_rd_v;
	logic [L2_MAX_WAYS-1:0][TW-1:0]      l2_rd_t;
	logic [L2_MAX_WAYS-1:0][A2-1:0]      l2_rd_a;

	// row buffer of the level at work
	logic [MW-1:0]         buf_v;
	logic [MW-1:0][TW-1:0] buf_t;
	logic [MW-1:0][AW-1:0] buf_a;
	logic [MW-1:0]         new_v;
	logic [MW-1:0][TW-1:0] new_t;
	logic [MW-1:0][AW-1:0] new_a;

	logic [NWW-1:0] nw_c;
	logic [RBM-1:0] row_c;
	logic [TW-1:0]  tag_c;
	logic           upd_fire;
	logic           go_l2;
	logic           clr_l1, clr_l2;
	logic           scan_v, scan_hit, scan_cand, scan_end;
	logic [AW-1:0]  scan_age;
	logic [AW-1:0]  best_n;
	logic [IW-1:0]  w_n;
	logic [NWW-1:0] idx_next;

	// effective way count of the level at work
	always_comb begin
		nw_c = NWW'(1);
		if (!level_q) begin
			if (l1_ways_q == 3'd0)
				nw_c = NWW'(1);
			else if (5'(l1_ways_q) > 5'(L1_MAX_WAYS))
				nw_c = NWW'(L1_MAX_WAYS);
			else
				nw_c = NWW'(l1_ways_q);
		end else begin
			if (l2_ways_q == 4'd0)
				nw_c = NWW'(1);
			else if (5'(l2_ways_q) > 5'(L2_MAX_WAYS))
				nw_c = NWW'(L2_MAX_WAYS);
			else
				nw_c = NWW'(l2_ways_q);
		end
	end

	// row and tag split of the address
	always_comb begin
		logic [1:0]            bs;
		logic [3:0]            rs;
		logic [TW-1:0]         blk;
		logic [TW-1:0]         rfull;
		logic [TW+RBM-1:0]     rext;
		if (!level_q) begin
			bs = l1_bs_q;
			rs = (4'(l1_rs_q) > 4'(FL1)) ? 4'(FL1) : 4'(l1_rs_q);
		end else begin
			bs = l2_bs_q;
			rs = (l2_rs_q > 4'(FL2)) ? 4'(FL2) : l2_rs_q;
		end
		blk   = req_q.addr >> bs;
		rfull = blk & ~({TW{1'b1}} << rs);
		rext  = (TW+RBM)'(rfull);
		row_c = rext[RBM-1:0];
		tag_c = blk >> rs;
	end

	// read data of the selected level into a common row buffer
	always_comb begin
		buf_v = '0;
		buf_t = '0;
		buf_a = '0;
		if (!level_q) begin
			for (int i = 0; i < L1_MAX_WAYS; i++) begin
				buf_v[i] = l1_rd_v[i];
				buf_t[i] = l1_rd_t[i];
				buf_a[i] = AW'(l1_rd_a[i]);
			end
		end else begin
			for (int i = 0; i < L2_MAX_WAYS; i++) begin
				buf_v[i] = l2_rd_v[i];
				buf_t[i] = l2_rd_t[i];
				buf_a[i] = AW'(l2_rd_a[i]);
			end
		end
	end

	// one way per cycle through the shared comparator
	always_comb begin
		scan_v    = buf_v[idx_q];
		scan_age  = buf_a[idx_q];
		scan_hit  = scan_v && (buf_t[idx_q] == tag_q);
		scan_cand = (idx_q == '0) || (scan_age > best_q);
		best_n    = scan_cand ? scan_age : best_q;
		w_n       = scan_cand ? idx_q : w_q;
		idx_next  = NWW'(idx_q) + NWW'(1);
		scan_end  = (idx_next == nw_c);
	end

	// new row: chosen way to most recent, younger valid ways age by one
	always_comb begin
		for (int i = 0; i < MW; i++) begin
			new_v[i] = buf_v[i];
			new_t[i] = buf_t[i];
			new_a[i] = buf_a[i];
			if (CW'(i) < CW'(nw_c)) begin
				if (IW'(i) == w_q) begin
					new_v[i] = 1'b1;
					new_t[i] = tag_q;
					new_a[i] = '0;
				end else if (buf_v[i] && (CW'(buf_a[i]) < old_q) &&
						(CW'(buf_a[i]) + CW'(1) < CW'(nw_c))) begin
					new_a[i] = buf_a[i] + AW'(1);
				end
			end
		end
	end

	assign upd_fire = (state_q == S_UPD) && (!out_valid_q || out_ready);
	assign go_l2    = !level_q && l2_en_q && ((req_q.cmd == CMD_STORE) || !hit_q);
	assign clr_l1   = (state_q == S_CLR) && ({1'b0, clr_cnt_q} < (RBM+1)'(L1_MAX_ROWS));
	assign clr_l2   = (state_q == S_CLR) && ({1'b0, clr_cnt_q} < (RBM+1)'(L2_MAX_ROWS));

	// L1 memories
	always_ff @(posedge clk) begin
		if (clr_l1)
			l1_vmem[clr_cnt_q[R1B-1:0]] <= '0;
		else if (upd_fire && !level_q) begin
			for (int i = 0; i < L1_MAX_WAYS; i++) begin
				l1_vmem[row_q[R1B-1:0]][i] <= new_v[i];
				l1_tmem[row_q[R1B-1:0]][i] <= new_t[i];
				l1_amem[row_q[R1B-1:0]][i] <= A1'(new_a[i]);
			end
		end
		if (state_q == S_ADDR && !level_q) begin
			l1_rd_v <= l1_vmem[row_c[R1B-1:0]];
			l1_rd_t <= l1_tmem[row_c[R1B-1:0]];
			l1_rd_a <= l1_amem[row_c[R1B-1:0]];
		end
	end

	// L2 memories
	always_ff @(posedge clk) begin
		if (clr_l2)
			l2_vmem[clr_cnt_q[R2B-1:0]] <= '0;
		else if (upd_fire && level_q) begin
			for (int i = 0; i < L2_MAX_WAYS; i++) begin
				l2_vmem[row_q[R2B-1:0]][i] <= new_v[i];
				l2_tmem[row_q[R2B-1:0]][i] <= new_t[i];
				l2_amem[row_q[R2B-1:0]][i] <= A2'(new_a[i]);
			end
		end
		if (state_q == S_ADDR && level_q) begin
			l2_rd_v <= l2_vmem[row_c[R2B-1:0]];
			l2_rd_t <= l2_tmem[row_c[R2B-1:0]];
			l2_rd_a <= l2_amem[row_c[R2B-1:0]];
		end
	end

	// setup registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_bs_q   <= '0;
			l1_rs_q   <= '0;
			l1_ways_q <= 3'd1;
			l2_en_q   <= 1'b0;
			l2_bs_q   <= '0;
			l2_rs_q   <= '0;
			l2_ways_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_L1_BLOCK_SHIFT: l1_bs_q   <= cfg_data[1:0];
				CFG_L1_ROW_SHIFT:   l1_rs_q   <= cfg_data[2:0];
				CFG_L1_WAYS:        l1_ways_q <= cfg_data[2:0];
				CFG_L2_ENABLE:      l2_en_q   <= cfg_data[0];
				CFG_L2_BLOCK_SHIFT: l2_bs_q   <= cfg_data[1:0];
				CFG_L2_ROW_SHIFT:   l2_rs_q   <= cfg_data[3:0];
				CFG_L2_WAYS:        l2_ways_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_cnt_q   <= '0;
			level_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: loaded by the update step, else drained
			if (upd_fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + RBM'(1);
					if ({1'b0, clr_cnt_q} == (RBM+1)'(MAXR - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= in_data;
						level_q <= 1'b0;
						state_q <= S_ADDR;
					end
				end
				S_ADDR: begin
					row_q   <= row_c;
					tag_q   <= tag_c;
					idx_q   <= '0;
					w_q     <= '0;
					best_q  <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (!scan_v) begin
						hit_q   <= 1'b0;
						w_q     <= idx_q;
						old_q   <= CW'(nw_c);
						state_q <= S_UPD;
					end else if (scan_hit) begin
						hit_q   <= 1'b1;
						w_q     <= idx_q;
						old_q   <= CW'(scan_age);
						state_q <= S_UPD;
					end else begin
						best_q <= best_n;
						w_q    <= w_n;
						if (scan_end) begin
							hit_q   <= 1'b0;
							old_q   <= CW'(best_n);
							state_q <= S_UPD;
						end else begin
							idx_q <= IW'(idx_next);
						end
					end
				end
				S_UPD: begin
					if (upd_fire) begin
						if (go_l2) begin
							level_q <= 1'b1;
							state_q <= S_ADDR;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		logic [RBM+7:0] rix;
		rix = (RBM+8)'(row_q);
		if (upd_fire) begin
			out_q.level     <= level_q;
			out_q.status    <= (req_q.cmd == CMD_STORE) ? ST_SW : (hit_q ? ST_HIT : ST_MISS);
			out_q.row_index <= rix[7:0];
			out_q.addr_echo <= req_q.addr;
			out_q.pc_echo   <= req_q.pc_value;
			out_q.last      <= !go_l2;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !in_ready)
		else $error("request taken during clearing pass");
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (NWW'(idx_q) < nw_c))
		else $error("way scan beyond way count");
	a_l2_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.level) |-> out_data.last)
		else $error("L2 result not marked last");
	a_update_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		upd_fire |=> out_valid_q)
		else $error("update did not load the result register");
`endif

endmodule

### dv/tb_two_level_lru_cache_tag_model.sv
// Testbench for the two-level LRU cache tag model: directed and random requests,
// checked against a behavioral tag/LRU predictor of both levels.
// Depends on tllc_pkg and two_level_lru_cache_tag_model.
`timescale 1ns / 100ps

module tb_two_level_lru_cache_tag_model;
	import tllc_pkg::*;

	localparam int L1R = L1_MAX_ROWS_DEF;
	localparam int L1W = L1_MAX_WAYS_DEF;
	localparam int L2R = L2_MAX_ROWS_DEF;
	localparam int L2W = L2_MAX_WAYS_DEF;
	localparam int WDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	always #5 clk = ~clk;

	two_level_lru_cache_tag_model u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state: shadow copy of both tag arrays and the setup registers.
	bit                 l1_vld [L1R*L1W];
	bit [ADDR_BITS-1:0] l1_tag [L1R*L1W];
	int unsigned        l1_age [L1R*L1W];
	bit                 l2_vld [L2R*L2W];
	bit [ADDR_BITS-1:0] l2_tag [L2R*L2W];
	int unsigned        l2_age [L2R*L2W];
	int unsigned        sh_l1_bs, sh_l1_rs, sh_l1_w, sh_l2_en, sh_l2_bs, sh_l2_rs, sh_l2_w;

	rsp_t expected_rsps[$];
	int   n_errors;
	int   n_reqs;
	int   n_rsps;
	int   idle_cycles;
	bit   rx_stall_on;

	// One level's lookup + LRU update; returns status, row through output arg.
	function automatic logic [1:0] access_level(input bit lv, input bit [ADDR_BITS-1:0] a,
			input bit wr, output logic [7:0] row_o);
		int unsigned maxr, maxw, bs, rs, nw, row, base, w, old, best;
		int hit, empty;
		bit [ADDR_BITS-1:0] blk, tg;
		bit v;
		maxr = lv ? L2R : L1R;
		maxw = lv ? L2W : L1W;
		bs = lv ? sh_l2_bs : sh_l1_bs;
		rs = lv ? sh_l2_rs : sh_l1_rs;
		nw = lv ? sh_l2_w : sh_l1_w;
		while (rs > 0 && (1 << rs) > maxr) rs--;
		if (nw == 0) nw = 1;
		if (nw > maxw) nw = maxw;
		blk = a >> bs;
		row = blk & ((1 << rs) - 1);
		tg = blk >> rs;
		base = row * maxw;
		row_o = row[7:0];
		hit = -1;
		empty = -1;
		// scan stops at the first empty way or the first tag match
		for (int i = 0; i < nw; i++) begin
			v = lv ? l2_vld[base+i] : l1_vld[base+i];
			if (!v) begin
				empty = i;
				break;
			end
			if ((lv ? l2_tag[base+i] : l1_tag[base+i]) == tg) begin
				hit = i;
				break;
			end
		end
		if (hit >= 0) w = hit;
		else if (empty >= 0) w = empty;
		else begin
			// oldest way wins; ties go to the lowest index
			w = 0;
			best = 0;
			for (int i = 0; i < nw; i++) begin
				old = lv ? l2_age[base+i] : l1_age[base+i];
				if (i == 0 || old > best) begin
					best = old;
					w = i;
				end
			end
		end
		v = lv ? l2_vld[base+w] : l1_vld[base+w];
		old = v ? (lv ? l2_age[base+w] : l1_age[base+w]) : nw;
		for (int i = 0; i < nw; i++) begin
			if (lv) begin
				if (i != w && l2_vld[base+i] && l2_age[base+i] < old && l2_age[base+i] + 1 < nw)
					l2_age[base+i]++;
			end else begin
				if (i != w && l1_vld[base+i] && l1_age[base+i] < old && l1_age[base+i] + 1 < nw)
					l1_age[base+i]++;
			end
		end
		if (lv) begin
			l2_age[base+w] = 0;
			l2_vld[base+w] = 1;
			l2_tag[base+w] = tg;
		end else begin
			l1_age[base+w] = 0;
			l1_vld[base+w] = 1;
			l1_tag[base+w] = tg;
		end
		if (wr) return ST_SW;
		return (hit >= 0) ? ST_HIT : ST_MISS;
	endfunction

	function automatic void predict_access(input req_t r);
		rsp_t e;
		logic [7:0] row;
		bit to_l2;
		e.addr_echo = r.addr;
		e.pc_echo = r.pc_value;
		e.level = 1'b0;
		e.status = access_level(1'b0, r.addr, r.cmd == CMD_STORE, row);
		e.row_index = row;
		to_l2 = sh_l2_en != 0 && (r.cmd == CMD_STORE || e.status == ST_MISS);
		e.last = !to_l2;
		expected_rsps.insert(expected_rsps.size(), e);
		if (to_l2) begin
			e.level = 1'b1;
			e.status = access_level(1'b1, r.addr, r.cmd == CMD_STORE, row);
			e.row_index = row;
			e.last = 1'b1;
			expected_rsps.insert(expected_rsps.size(), e);
		end
	endfunction

	// Drive one register; shadow copy follows the same masking.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		case (idx)
			CFG_L1_BLOCK_SHIFT: sh_l1_bs = val & 3;
			CFG_L1_ROW_SHIFT:   sh_l1_rs = val & 7;
			CFG_L1_WAYS:        sh_l1_w = val & 7;
			CFG_L2_ENABLE:      sh_l2_en = val & 1;
			CFG_L2_BLOCK_SHIFT: sh_l2_bs = val & 3;
			CFG_L2_ROW_SHIFT:   sh_l2_rs = val & 15;
			CFG_L2_WAYS:        sh_l2_w = val & 15;
			default: ;
		endcase
	endtask

	// Stop offering requests, wait for every result, then some idle slack.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_config(input int unsigned b1, r1, w1, en, b2, r2, w2);
		wait_drained();
		write_reg(CFG_L1_BLOCK_SHIFT, b1);
		write_reg(CFG_L1_ROW_SHIFT, r1);
		write_reg(CFG_L1_WAYS, w1);
		write_reg(CFG_L2_ENABLE, en);
		write_reg(CFG_L2_BLOCK_SHIFT, b2);
		write_reg(CFG_L2_ROW_SHIFT, r2);
		write_reg(CFG_L2_WAYS, w2);
		cfg_we <= 1'b0;
	endtask

	// Send one request after a random gap; prediction happens on acceptance.
	// Valid stays high after acceptance until the next gap or drain drops it.
	task automatic send_request(input logic c, input logic [ADDR_BITS-1:0] a,
			input logic [15:0] pc, input bit no_gap = 0);
		int gap;
		req_t r;
		gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		r.cmd = c;
		r.addr = a;
		r.pc_value = pc;
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_access(r);
		n_reqs++;
	endtask

	task automatic rand_request(input int unsigned addr_span);
		send_request(1'($urandom_range(0, 1)), 13'($urandom_range(0, addr_span)),
			16'($urandom_range(0, 16'hFFFF)));
	endtask

	// Result checker.
	always @(posedge clk) begin
		rsp_t e;
		if (out_valid && out_ready) begin
			n_rsps++;
			if (expected_rsps.size() == 0) begin
				$error("unexpected result %p", out_data);
				n_errors++;
			end else begin
				e = expected_rsps.pop_front();
				if (out_data.level !== e.level) begin
					$error("level exp %0d got %0d", e.level, out_data.level); n_errors++;
				end
				if (out_data.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, out_data.status); n_errors++;
				end
				if (out_data.row_index !== e.row_index) begin
					$error("row_index exp %0d got %0d", e.row_index, out_data.row_index);
					n_errors++;
				end
				if (out_data.addr_echo !== e.addr_echo) begin
					$error("addr_echo exp %0h got %0h", e.addr_echo, out_data.addr_echo);
					n_errors++;
				end
				if (out_data.pc_echo !== e.pc_echo) begin
					$error("pc_echo exp %0h got %0h", e.pc_echo, out_data.pc_echo);
					n_errors++;
				end
				if (out_data.last !== e.last) begin
					$error("last exp %0d got %0d", e.last, out_data.last); n_errors++;
				end
			end
		end
	end

	// Receiver: after each result, may stall when rx_stall_on is set (or not at all).
	initial begin
		int st;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				st = rx_stall_on ? $urandom_range(0, 16) : 0;
				if (st != 0) begin
					out_ready <= 1'b0;
					repeat (st) @(posedge clk);
				end
				out_ready <= 1'b1;
			end else if (arst_n) begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: cycles with no handshake on either channel and no setup write.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Reset defaults; L1 direct-mapped single row, fill/hit/evict edge values.
	task automatic test_reset_defaults();
		send_request(1'b0, 13'h0000, 16'h0000);
		send_request(1'b0, 13'h0000, 16'hFFFF);
		send_request(1'b0, 13'h1FFF, 16'hA5A5);
		send_request(1'b1, 13'h1FFF, 16'h5A5A);
		send_request(1'b0, 13'h1FFF, 16'h1234);
	endtask

	// Oversize row shifts, zero/oversize ways, max geometry with L2 on.
	task automatic test_corner_config();
		set_config(3, 7, 0, 1, 3, 15, 0);
		send_request(1'b0, 13'h1FFF, 16'h0001);
		send_request(1'b1, 13'h1FF8, 16'h0002);
		send_request(1'b0, 13'h0AAA, 16'h0003);
		set_config(0, 6, 7, 1, 0, 8, 15);
		// same row, many tags: fill all ways, then evict the LRU one
		for (int i = 0; i < 10; i++)
			send_request(1'b0, 13'(i << 8), 16'(i));
		send_request(1'b0, 13'h0000, 16'h00F0);
		send_request(1'b1, 13'h0100, 16'h00F1);
		send_request(1'b1, 13'h1F00, 16'h00F2);
	endtask

	// Mid-run change with contents kept: shrink ways so ages get capped.
	task automatic test_shrink_ways();
		set_config(0, 6, 2, 1, 0, 8, 3);
		for (int i = 0; i < 8; i++)
			send_request(1'($urandom_range(0, 1)), 13'((i % 5) << 8), 16'(i));
	endtask

	// Random phases over several geometries; narrow and full address spans alternate.
	task automatic test_random_phases();
		int unsigned span;
		for (int p = 0; p < 8; p++) begin
			set_config($urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 7),
				$urandom_range(0, 1), $urandom_range(0, 3), $urandom_range(0, 15),
				$urandom_range(0, 15));
			rx_stall_on = (p % 3) != 2;
			span = (p % 2) ? 13'h1FFF : 13'h01FF;
			for (int i = 0; i < 95; i++) begin
				rand_request(span);
				// sender holds off until the block has drained
				if (i == 40) wait_drained();
			end
		end
		// back-to-back burst with no gaps on either side
		rx_stall_on = 0;
		for (int i = 0; i < 30; i++)
			send_request(1'($urandom_range(0, 1)), 13'($urandom_range(0, 13'h1FFF)),
				16'($urandom_range(0, 16'hFFFF)), 1);
		rx_stall_on = 1;
	endtask

	initial begin
		n_errors = 0;
		n_reqs = 0;
		n_rsps = 0;
		idle_cycles = 0;
		rx_stall_on = 1;
		sh_l1_bs = 0; sh_l1_rs = 0; sh_l1_w = 1; sh_l2_en = 0;
		sh_l2_bs = 0; sh_l2_rs = 0; sh_l2_w = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_corner_config();
		test_shrink_ways();
		test_random_phases();

		wait_drained();
		$display("covered %0d requests and %0d results across corner and random geometries",
			n_reqs, n_rsps);
		if (n_errors == 0 && expected_rsps.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
